// File: design/lgs_pkg.sv
package lgs_pkg;

	// Default grid bounds, handed down as top-level parameter defaults
	localparam int DEF_MAX_COLS = 256;
	localparam int DEF_MAX_ROWS = 64;

	// Fixed field widths
	localparam int CMD_W     = 2;
	localparam int IDX_W     = 14;
	localparam int POP_W     = 15;
	localparam int COLS_W    = 9;
	localparam int ROWS_W    = 7;
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 1;
	localparam int DIV_CNT_W = $clog2(IDX_W);

	// Smallest usable grid dimension
	localparam int MIN_DIM = 3;
	localparam logic [COLS_W-1:0] COLS_MIN = COLS_W'(MIN_DIM);
	localparam logic [ROWS_W-1:0] ROWS_MIN = ROWS_W'(MIN_DIM);

	// Register reset values
	localparam logic [COLS_W-1:0] COLS_RST = 9'd140;
	localparam logic [ROWS_W-1:0] ROWS_RST = 7'd40;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b1;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [IDX_W-1:0] cell_index;
		logic             cell_alive;
	} cmd_item_t;

	typedef struct packed {
		logic             cell_state;
		logic [POP_W-1:0] population;
		logic             grid_empty;
	} rsp_item_t;

	// Controller -> datapath
	typedef struct packed {
		logic accept;
		logic clr_step;
		logic div_start;
		logic cell_rd;
		logic cell_wb;
		logic gen_rd0;
		logic gen_rd1;
		logic gen_ld;
		logic gen_cell;
		logic gen_wr;
		logic rsp_load;
	} ctl_t;

	// Datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic div_busy;
		logic col_last;
		logic row_last;
		logic rsp_free;
	} stat_t;

endpackage

// File: design/lgs_div.sv
module lgs_div #(
	parameter int CNT_W = 9
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [lgs_pkg::IDX_W-1:0] dividend,
	input  logic [CNT_W-1:0]          divisor,
	output logic                      busy,
	output logic [lgs_pkg::IDX_W-1:0] quotient,
	output logic [CNT_W-1:0]          remainder
);

	localparam int IW = lgs_pkg::IDX_W;
	localparam int CW = lgs_pkg::DIV_CNT_W;

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [IW-1:0] quo_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] dvs_q;

	logic [CNT_W:0] r_sh;
	logic [CNT_W:0] diff;
	logic           ge;

	// restoring division, one quotient bit per cycle
	always_comb begin
		r_sh = {rem_q, quo_q[IW-1]};
		ge   = r_sh >= {1'b0, dvs_q};
		diff = r_sh - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(IW - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[IW-2:0], ge};
			rem_q <= ge ? diff[CNT_W-1:0] : r_sh[CNT_W-1:0];
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// File: design/lgs_dpath.sv
module lgs_dpath #(
	parameter int MAX_COLS = lgs_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = lgs_pkg::DEF_MAX_ROWS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lgs_pkg::CFG_W-1:0]     cfg_data,
	input  lgs_pkg::cmd_item_t            cmd,
	input  lgs_pkg::ctl_t                 ctl,
	output lgs_pkg::stat_t                st,
	input  logic                          rsp_stall,
	output logic                          rsp_valid,
	output lgs_pkg::rsp_item_t            rsp
);

	localparam int CNT_W  = $clog2(MAX_COLS + 1);
	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int RCNT_W = $clog2(MAX_ROWS + 1);
	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int IW     = lgs_pkg::IDX_W;
	localparam int PW     = lgs_pkg::POP_W;

	// configuration
	logic [lgs_pkg::COLS_W-1:0] cols_q;
	logic [lgs_pkg::ROWS_W-1:0] rows_q;
	logic [CNT_W-1:0]  nc;
	logic [RCNT_W-1:0] nr;

	// grid memory, one row per word
	logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
	logic                mem_we;
	logic [ROW_W-1:0]    mem_waddr;
	logic [MAX_COLS-1:0] mem_wdata;
	logic                mem_re;
	logic [ROW_W-1:0]    mem_raddr;
	logic [MAX_COLS-1:0] rd_data_q;

	// item and results
	lgs_pkg::cmd_item_t item_q;
	logic               state_q;
	logic [PW-1:0]      live_q;
	lgs_pkg::rsp_item_t rsp_q;
	logic               rsp_valid_q;

	// clear sweep
	logic [ROW_W-1:0] clr_row_q;

	// cell access
	logic [IW-1:0]    quo;
	logic [CNT_W-1:0] rem;
	logic             div_busy;
	logic             on_grid;
	logic [COL_W-1:0] cell_col;
	logic [ROW_W-1:0] cell_row;
	logic             old_bit;
	logic             is_write;
	logic [MAX_COLS-1:0] mod_row;

	// generation window
	logic [MAX_COLS-1:0] above_q, cur_q, below_q, new_row_q;
	logic [ROW_W-1:0]    row_q;
	logic [COL_W-1:0]    col_q;
	logic [PW-1:0]       pop_acc_q;
	logic [MAX_COLS+1:0] pad_a, pad_c, pad_b;
	logic [2:0]          wa, wc, wb;
	logic [3:0]          nbr;
	logic                nxt;
	logic                below_in;

	// effective geometry, saturated into the legal range
	always_comb begin
		if (cols_q < lgs_pkg::COLS_MIN) begin
			nc = CNT_W'(lgs_pkg::MIN_DIM);
		end else if (32'(cols_q) > 32'(MAX_COLS)) begin
			nc = CNT_W'(MAX_COLS);
		end else begin
			nc = CNT_W'(cols_q);
		end
		if (rows_q < lgs_pkg::ROWS_MIN) begin
			nr = RCNT_W'(lgs_pkg::MIN_DIM);
		end else if (32'(rows_q) > 32'(MAX_ROWS)) begin
			nr = RCNT_W'(MAX_ROWS);
		end else begin
			nr = RCNT_W'(rows_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= lgs_pkg::COLS_RST;
			rows_q <= lgs_pkg::ROWS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lgs_pkg::CFG_COLS: cols_q <= cfg_data[lgs_pkg::COLS_W-1:0];
				lgs_pkg::CFG_ROWS: rows_q <= cfg_data[lgs_pkg::ROWS_W-1:0];
				default: ;
			endcase
		end
	end

	lgs_div #(
		.CNT_W(CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (cmd.cell_index),
		.divisor  (nc),
		.busy     (div_busy),
		.quotient (quo),
		.remainder(rem)
	);

	assign on_grid  = 32'(quo) < 32'(nr);
	assign cell_col = rem[COL_W-1:0];
	assign cell_row = quo[ROW_W-1:0];
	assign is_write = item_q.command == lgs_pkg::CMD_WRITE;
	assign old_bit  = rd_data_q[cell_col];

	always_comb begin
		mod_row           = rd_data_q;
		mod_row[cell_col] = item_q.cell_alive;
	end

	// 3x3 window; zero padding makes columns outside the grid dead
	always_comb begin
		pad_a = {1'b0, above_q, 1'b0};
		pad_c = {1'b0, cur_q, 1'b0};
		pad_b = {1'b0, below_q, 1'b0};
		wa    = pad_a[col_q +: 3];
		wc    = pad_c[col_q +: 3];
		wb    = pad_b[col_q +: 3];
		nbr   = 4'(wa[0]) + 4'(wa[1]) + 4'(wa[2]) + 4'(wc[0]) + 4'(wc[2])
		      + 4'(wb[0]) + 4'(wb[1]) + 4'(wb[2]);
		nxt   = (nbr == 4'd3) || (wc[1] && nbr == 4'd2);
	end

	assign below_in = 32'(row_q) + 1 < 32'(nr);

	// memory port selection
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_row_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = row_q;
		if (ctl.clr_step) begin
			mem_we = 1'b1;
		end
		if (ctl.cell_wb && is_write && on_grid) begin
			mem_we    = 1'b1;
			mem_waddr = cell_row;
			mem_wdata = mod_row;
		end
		if (ctl.gen_wr) begin
			mem_we    = 1'b1;
			mem_waddr = row_q;
			mem_wdata = new_row_q;
			mem_re    = 1'b1;
			mem_raddr = ROW_W'(32'(row_q) + 2);
		end
		if (ctl.cell_rd) begin
			mem_re    = 1'b1;
			mem_raddr = cell_row;
		end
		if (ctl.gen_rd0) begin
			mem_re    = 1'b1;
			mem_raddr = '0;
		end
		if (ctl.gen_rd1) begin
			mem_re    = 1'b1;
			mem_raddr = ROW_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= grid_mem[mem_raddr];
		end
	end

	// control-side registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_row_q   <= '0;
			live_q      <= '0;
			state_q     <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				clr_row_q <= '0;
			end else if (ctl.clr_step) begin
				clr_row_q <= clr_row_q + ROW_W'(1);
			end

			if (ctl.clr_step) begin
				live_q <= '0;
			end else if (ctl.cell_wb && is_write && on_grid && old_bit != item_q.cell_alive) begin
				live_q <= item_q.cell_alive ? live_q + PW'(1) : live_q - PW'(1);
			end else if (ctl.gen_wr && st.row_last) begin
				live_q <= pop_acc_q;
			end

			if (ctl.accept) begin
				state_q <= 1'b0;
			end else if (ctl.cell_wb) begin
				state_q <= on_grid && (is_write ? item_q.cell_alive : old_bit);
			end

			if (ctl.gen_rd0) begin
				row_q <= '0;
			end else if (ctl.gen_wr) begin
				row_q <= row_q + ROW_W'(1);
			end

			if (ctl.gen_ld) begin
				col_q <= '0;
			end else if (ctl.gen_cell) begin
				col_q <= col_q + COL_W'(1);
			end

			if (ctl.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			item_q <= cmd;
		end
		if (ctl.gen_rd0) begin
			above_q   <= '0;
			pop_acc_q <= '0;
		end
		if (ctl.gen_rd1) begin
			cur_q <= rd_data_q;
		end
		if (ctl.gen_ld) begin
			below_q   <= below_in ? rd_data_q : '0;
			new_row_q <= '0;
		end
		if (ctl.gen_cell) begin
			new_row_q[col_q] <= nxt;
			pop_acc_q        <= pop_acc_q + PW'(nxt);
		end
		if (ctl.gen_wr) begin
			above_q <= cur_q;
			cur_q   <= below_q;
		end
		if (ctl.rsp_load) begin
			rsp_q.cell_state <= state_q;
			rsp_q.population <= live_q;
			rsp_q.grid_empty <= live_q == '0;
		end
	end

	assign st.clr_last = 32'(clr_row_q) + 1 == MAX_ROWS;
	assign st.div_busy = div_busy;
	assign st.col_last = 32'(col_q) + 1 == 32'(nc);
	assign st.row_last = 32'(row_q) + 1 == 32'(nr);
	assign st.rsp_free = !rsp_valid_q || !rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: design/lgs_ctrl.sv
module lgs_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cmd_valid,
	input  logic [lgs_pkg::CMD_W-1:0] command,
	output logic                      cmd_stall,
	output lgs_pkg::ctl_t             ctl,
	input  lgs_pkg::stat_t            st
);

	typedef enum logic [9:0] {
		S_CLEAR    = 10'b00_0000_0001,
		S_IDLE     = 10'b00_0000_0010,
		S_DIV      = 10'b00_0000_0100,
		S_CELL_WB  = 10'b00_0000_1000,
		S_GEN_RD0  = 10'b00_0001_0000,
		S_GEN_RD1  = 10'b00_0010_0000,
		S_GEN_LD   = 10'b00_0100_0000,
		S_GEN_CELL = 10'b00_1000_0000,
		S_GEN_WR   = 10'b01_0000_0000,
		S_RESP     = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_nxt;

	always_comb begin
		ctl       = '0;
		state_nxt = state_q;
		cmd_stall = (state_q != S_IDLE) || cfg_we;

		unique case (state_q)
			S_CLEAR: begin
				ctl.clr_step = 1'b1;
				if (st.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (cmd_valid && !cfg_we) begin
					ctl.accept = 1'b1;
					unique case (command) inside
						lgs_pkg::CMD_WRITE, lgs_pkg::CMD_READ: begin
							ctl.div_start = 1'b1;
							state_nxt     = S_DIV;
						end
						lgs_pkg::CMD_STEP: state_nxt = S_GEN_RD0;
						default:           state_nxt = S_RESP;
					endcase
				end
			end
			S_DIV: begin
				if (!st.div_busy) begin
					ctl.cell_rd = 1'b1;
					state_nxt   = S_CELL_WB;
				end
			end
			S_CELL_WB: begin
				ctl.cell_wb = 1'b1;
				state_nxt   = S_RESP;
			end
			S_GEN_RD0: begin
				ctl.gen_rd0 = 1'b1;
				state_nxt   = S_GEN_RD1;
			end
			S_GEN_RD1: begin
				ctl.gen_rd1 = 1'b1;
				state_nxt   = S_GEN_LD;
			end
			S_GEN_LD: begin
				ctl.gen_ld = 1'b1;
				state_nxt  = S_GEN_CELL;
			end
			S_GEN_CELL: begin
				ctl.gen_cell = 1'b1;
				if (st.col_last) begin
					state_nxt = S_GEN_WR;
				end
			end
			S_GEN_WR: begin
				ctl.gen_wr = 1'b1;
				state_nxt  = st.row_last ? S_RESP : S_GEN_LD;
			end
			S_RESP: begin
				if (st.rsp_free) begin
					ctl.rsp_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_CLEAR;
		endcase

		// geometry change wipes the grid
		if (cfg_we) begin
			state_nxt = S_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// File: design/life_generation_step_top.sv
// Game of Life engine (rule B3/S23) on a bit grid of up to MAX_COLS x MAX_ROWS cells.
// Command channel (cmd_valid/cmd_stall/cmd): write one cell, read one cell, or
// advance the whole grid one generation. Cells are addressed as row * columns + column;
// cells outside the grid count as dead. Every item gives exactly one result on the
// response channel (rsp_valid/rsp_stall/rsp): addressed cell, population, empty flag.
// Config port (cfg_we/cfg_index/cfg_data): index 0 = columns in use, 1 = rows in use.
// Values saturate into [3, MAX_COLS] and [3, MAX_ROWS]; any write wipes the grid.
// A write or read runs from accept to rsp_valid through the bit-serial index
// divider, one row read, one write-back and the result load. A generation step
// primes the row window from rows 0 and 1, then per row does one row load, each
// cell in turn through the 3x3 window and one write-back, then the result load.
// Items are worked one at a time.
// After reset, and after every config write, a clearing pass writes MAX_ROWS zero
// rows (64 at default) while cmd_stall stays high.
// The result sits in an output register; the next item is accepted while it waits.
// If rsp_stall holds, a finished item waits for the register and the block stalls.
module life_generation_step_top #(
	parameter int MAX_COLS = lgs_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = lgs_pkg::DEF_MAX_ROWS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lgs_pkg::CFG_W-1:0]     cfg_data,
	// command items
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  lgs_pkg::cmd_item_t            cmd,
	// result items
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output lgs_pkg::rsp_item_t            rsp
);

	lgs_pkg::ctl_t  ctl;
	lgs_pkg::stat_t st;

	// sequencer: clear pass, cell access, generation sweep, result hand-off
	lgs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cmd_valid(cmd_valid),
		.command  (cmd.command),
		.cmd_stall(cmd_stall),
		.ctl      (ctl),
		.st       (st)
	);

	// grid memory, row window, divider, counters and output register
	lgs_dpath #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.ctl      (ctl),
		.st       (st),
		.rsp_stall(rsp_stall),
		.rsp_valid(rsp_valid),
		.rsp      (rsp)
	);

endmodule

// File: verif/life_step_checker.sv
`timescale 1ns / 1ps

module life_step_checker
	import lgs_pkg::*;
#(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 cmd_valid,
	input  logic                 cmd_stall,
	input  cmd_item_t            cmd,
	input  logic                 rsp_valid,
	input  logic                 rsp_stall,
	input  rsp_item_t            rsp,
	output int                   pending,
	output int                   fail_count
);
	localparam int GRID_CELLS = MAX_COLS * MAX_ROWS;

	logic [COLS_W-1:0]   cols_reg;
	logic [ROWS_W-1:0]   rows_reg;
	bit [GRID_CELLS-1:0] life_grid;
	int unsigned         live_count;
	rsp_item_t           report_q[$];
	rsp_item_t           want;
	int                  open_count = 0;
	int                  errors = 0;

	assign pending    = open_count;
	assign fail_count = errors;

	function automatic int span_cols();
		if (cols_reg < MIN_DIM) return MIN_DIM;
		if (cols_reg > MAX_COLS) return MAX_COLS;
		return int'(cols_reg);
	endfunction

	function automatic int span_rows();
		if (rows_reg < MIN_DIM) return MIN_DIM;
		if (rows_reg > MAX_ROWS) return MAX_ROWS;
		return int'(rows_reg);
	endfunction

	// B3/S23, cells past any edge count as dead
	function automatic void advance_generation();
		bit [GRID_CELLS-1:0] next_gen;
		int nc, nr, r, c, dr, dc, rr, cc, n;
		int unsigned total;
		nc = span_cols();
		nr = span_rows();
		next_gen = '0;
		total = 0;
		for (r = 0; r < nr; r++) begin
			for (c = 0; c < nc; c++) begin
				n = 0;
				for (dr = -1; dr <= 1; dr++) begin
					for (dc = -1; dc <= 1; dc++) begin
						rr = r + dr;
						cc = c + dc;
						if (!(dr == 0 && dc == 0) && rr >= 0 && cc >= 0 && rr < nr && cc < nc)
							n += life_grid[rr * nc + cc];
					end
				end
				if (n == 3 || (life_grid[r * nc + c] && n == 2)) begin
					next_gen[r * nc + c] = 1'b1;
					total++;
				end
			end
		end
		life_grid = next_gen;
		live_count = total;
	endfunction

	function automatic rsp_item_t apply_command(input cmd_item_t c);
		rsp_item_t r;
		bit on_grid;
		on_grid = int'(c.cell_index) < span_cols() * span_rows();
		r.cell_state = 1'b0;
		case (c.command)
			CMD_WRITE: begin
				if (on_grid) begin
					if (life_grid[c.cell_index] != c.cell_alive) begin
						if (c.cell_alive) live_count++;
						else live_count--;
						life_grid[c.cell_index] = c.cell_alive;
					end
					r.cell_state = c.cell_alive;
				end
			end
			CMD_READ: begin
				if (on_grid) r.cell_state = life_grid[c.cell_index];
			end
			CMD_STEP: begin
				advance_generation();
			end
			default: ;
		endcase
		r.population = live_count[POP_W-1:0];
		r.grid_empty = (live_count == 0);
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (act_v !== exp_v) begin
			errors++;
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_reg = COLS_RST;
			rows_reg = ROWS_RST;
			life_grid = '0;
			live_count = 0;
			report_q.delete();
			open_count = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (report_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: expected none, got state %0b pop %0d empty %0b",
						$time, rsp.cell_state, rsp.population, rsp.grid_empty);
				end else begin
					want = report_q.pop_front();
					check_field("cell_state", want.cell_state, rsp.cell_state);
					check_field("population", want.population, rsp.population);
					check_field("grid_empty", want.grid_empty, rsp.grid_empty);
				end
			end
			// any geometry write wipes the grid
			if (cfg_we) begin
				case (cfg_index)
					CFG_COLS: cols_reg = cfg_data[COLS_W-1:0];
					CFG_ROWS: rows_reg = cfg_data[ROWS_W-1:0];
					default: ;
				endcase
				life_grid = '0;
				live_count = 0;
			end
			if (cmd_valid && !cmd_stall) report_q.push_back(apply_command(cmd));
			open_count = report_q.size();
		end
	end

endmodule

// File: verif/tb_life_generation_step_top.sv
`timescale 1ns / 1ps

module tb_life_generation_step_top;
	import lgs_pkg::*;

	// command 3 has no meaning: it changes nothing and only reports the population and empty flag
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	// the limit must cover a full 256x64 generation, which runs with no handshake
	localparam int WATCHDOG_LIMIT = 120000;
	// quiet time after the last result, to catch stray outputs
	localparam int DRAIN_CYCLES = 64;
	localparam int GRID_LIMIT = DEF_MAX_COLS * DEF_MAX_ROWS;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 cmd_valid;
	logic                 cmd_stall;
	cmd_item_t            cmd;
	logic                 rsp_valid;
	logic                 rsp_stall;
	rsp_item_t            rsp;

	int sender_idle_pct;
	int rsp_stall_pct;
	int pending;
	int fail_count;
	int quiet_cycles = 0;
	int k;

	life_generation_step_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// watches both channels and the config port, predicts every result
	life_step_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.pending    (pending),
		.fail_count (fail_count)
	);

	always #4 clk = ~clk;

	// receiver back-pressure, redrawn every cycle
	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
	end

	// watchdog: any handshake or config write restarts the count
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic cmd_item_t op(input logic [CMD_W-1:0] c, input int idx, input bit alive);
		cmd_item_t item;
		item.command = c;
		item.cell_index = IDX_W'(idx);
		item.cell_alive = alive;
		return item;
	endfunction

	function automatic int fit_dim(input int v, input int hi);
		return (v < MIN_DIM) ? MIN_DIM : (v > hi) ? hi : v;
	endfunction

	// Mostly writes of live cells onto the grid, so patterns form and then evolve under
	// the steps; reads sample the result. One index in ten is drawn from the whole
	// 14-bit range, which lands outside the grid on anything but the largest size.
	function automatic cmd_item_t random_item(input int area, input int step_pct);
		cmd_item_t item;
		int roll;
		roll = $urandom_range(99);
		if (roll < 5) item.command = CMD_UNUSED;
		else if (roll < 5 + step_pct) item.command = CMD_STEP;
		else if (roll < 70) item.command = CMD_WRITE;
		else item.command = CMD_READ;
		if ($urandom_range(9) == 0) item.cell_index = IDX_W'($urandom_range(GRID_LIMIT - 1));
		else item.cell_index = IDX_W'($urandom_range(area - 1));
		item.cell_alive = ($urandom_range(9) < 7);
		return item;
	endfunction

	// Valid stays high from one item to the next unless a gap is drawn; a gap drops
	// valid at one falling edge and raises it again at a later one.
	task automatic push_command(input cmd_item_t item);
		@(negedge clk);
		if ($urandom_range(99) < sender_idle_pct) begin
			cmd_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		cmd <= item;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
	endtask

	// stop sending and wait for every outstanding result
	task automatic drain_results();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		// a write kicks off a clearing pass; wait until items are taken again
		do @(posedge clk); while (cmd_stall);
	endtask

	// new geometry, new idling mix, then a burst of random items
	task automatic run_phase(input logic [CFG_W-1:0] cols_val, input logic [CFG_W-1:0] rows_val,
			input int idle_pct, input int stall_pct, input int count);
		int area;
		area = fit_dim(cols_val, DEF_MAX_COLS) * fit_dim(rows_val[ROWS_W-1:0], DEF_MAX_ROWS);
		drain_results();
		write_reg(CFG_COLS, cols_val);
		write_reg(CFG_ROWS, rows_val);
		sender_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		// big grids make steps expensive, so they get few
		repeat (count) push_command(random_item(area, (area <= 1024) ? 20 : 3));
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_COLS;
		cfg_data = '0;
		cmd_valid = 1'b0;
		cmd = '0;
		rsp_stall = 1'b0;
		sender_idle_pct = 0;
		rsp_stall_pct = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed items on the reset geometry (140 x 40), no idling.
		// Empty grid: read and step both report zero population.
		push_command(op(CMD_READ, 0, 1'b0));
		push_command(op(CMD_STEP, 0, 1'b0));
		// set, set again (no change), clear
		push_command(op(CMD_WRITE, 0, 1'b1));
		push_command(op(CMD_WRITE, 0, 1'b1));
		push_command(op(CMD_WRITE, 0, 1'b0));
		// addresses past the grid: write ignored, read gives dead
		push_command(op(CMD_WRITE, 140 * 40, 1'b1));
		push_command(op(CMD_WRITE, GRID_LIMIT - 1, 1'b1));
		push_command(op(CMD_READ, GRID_LIMIT - 1, 1'b0));
		push_command(op(CMD_UNUSED, GRID_LIMIT - 1, 1'b1));
		// Vertical blinker on the last column, rows 0..2. The right-hand neighbors
		// fall off the grid and must not wrap onto column 0 of the next row.
		push_command(op(CMD_WRITE, 139, 1'b1));
		push_command(op(CMD_WRITE, 140 + 139, 1'b1));
		push_command(op(CMD_WRITE, 280 + 139, 1'b1));
		push_command(op(CMD_UNUSED, 0, 1'b0));
		push_command(op(CMD_STEP, 0, 1'b0));
		push_command(op(CMD_READ, 140 + 138, 1'b0));
		push_command(op(CMD_READ, 139, 1'b0));
		push_command(op(CMD_STEP, 0, 1'b0));
		// block still life in the bottom-right corner, last cell included
		push_command(op(CMD_WRITE, 38 * 140 + 138, 1'b1));
		push_command(op(CMD_WRITE, 38 * 140 + 139, 1'b1));
		push_command(op(CMD_WRITE, 39 * 140 + 138, 1'b1));
		push_command(op(CMD_WRITE, 39 * 140 + 139, 1'b1));
		push_command(op(CMD_STEP, 0, 1'b0));
		push_command(op(CMD_READ, 39 * 140 + 139, 1'b0));

		// Random phases over several geometries and idling mixes.
		run_phase(9'd5, 9'd5, 0, 0, 20);
		// zero saturates to the 3 x 3 minimum
		run_phase(9'd0, 9'd0, 53, 0, 14);
		run_phase(9'd16, 9'd8, 0, 53, 20);
		// all ones saturate to 256 columns; the row register keeps 7 bits -> 127 -> 64
		run_phase(9'h1FF, 9'h1FF, 13, 13, 10);
		// blinker on the last row and columns of the full grid, then one full step
		for (k = GRID_LIMIT - 3; k < GRID_LIMIT; k++) push_command(op(CMD_WRITE, k, 1'b1));
		push_command(op(CMD_STEP, 0, 1'b0));
		push_command(op(CMD_READ, GRID_LIMIT - 2, 1'b0));
		// upper row bits set but dropped by the 7-bit row register -> 6 rows
		run_phase(9'd10, 9'h186, 13, 13, 20);
		run_phase(9'd256, 9'd3, 0, 53, 12);

		drain_results();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
